// ===== sv/fcsp_pkg.sv =====
package fcsp_pkg;

  localparam int unsigned ChannelCount = 4;
  localparam int unsigned CountWidth   = 16;

  localparam int unsigned TopWidth     = 16;
  localparam int unsigned CmpWidth     = 13;
  localparam int unsigned ChanWidth    = 8;
  localparam int unsigned DegWidth     = 16;
  localparam int unsigned LevelWidth   = 4;
  localparam int unsigned ChosenWidth  = 3;
  localparam int unsigned ChanIdxWidth = (ChannelCount > 1) ? $clog2(ChannelCount) : 1;
  // holds the clamped channel number 1..ChannelCount
  localparam int unsigned ChanNumWidth = $clog2(ChannelCount + 1);
  localparam int unsigned CntCmpWidth  = (CountWidth > TopWidth) ? CountWidth : TopWidth;

  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 24;

  localparam logic [TopWidth-1:0] PeriodTopReset = 16'd39999;
  localparam logic [CmpWidth-1:0] IdleCompare    = 13'd1000;
  localparam logic [CmpWidth-1:0] MaxCompare     = 13'd5000;
  localparam logic [DegWidth-1:0] MaxDegrees     = 16'd180;

  // floor(d * 100 / 9) == (d * 1456400) >> 17 for every d below 180
  localparam int unsigned DegRecipWidth = 21;
  localparam logic [DegRecipWidth-1:0] DegRecip = 21'd1456400;
  localparam int unsigned DegShift      = 17;

  // item kinds carried in tuser
  localparam logic ModeTick = 1'b0;
  localparam logic ModeSet  = 1'b1;

  // configuration register indexes
  localparam logic CfgPeriodTop = 1'b0;
  localparam logic CfgRunEnable = 1'b1;

  typedef struct packed {
    logic                    tick;
    logic                    set;
    logic [ChanIdxWidth-1:0] idx;
    logic [CmpWidth-1:0]     cmp;
  } fcsp_req_t;

  typedef struct packed {
    logic [LevelWidth-1:0] levels;
    logic                  wrapped;
  } fcsp_stat_t;

endpackage

// ===== sv/fcsp_servo_map.sv =====
module fcsp_servo_map import fcsp_pkg::*; (
  input  logic [ChanWidth-1:0]    channel_i,
  input  logic [DegWidth-1:0]     degrees_i,
  output logic [ChanNumWidth-1:0] chan_num_o,
  output logic [ChanIdxWidth-1:0] chan_idx_o,
  output logic [CmpWidth-1:0]     compare_o
);

  logic signed [ChanWidth-1:0]            ch_s;
  logic [ChanWidth-1:0]                   ch_clamped;
  logic [8+DegRecipWidth-1:0]             prod;
  logic [CmpWidth-3:0]                    quot;

  assign ch_s = $signed(channel_i);

  always_comb begin
    if (ch_s < $signed(ChanWidth'(1))) begin
      ch_clamped = ChanWidth'(1);
    end else if (ch_s > $signed(ChanWidth'(ChannelCount))) begin
      ch_clamped = ChanWidth'(ChannelCount);
    end else begin
      ch_clamped = channel_i;
    end
  end

  assign chan_num_o = ch_clamped[ChanNumWidth-1:0];
  assign chan_idx_o = ChanIdxWidth'(ch_clamped - ChanWidth'(1));

  // only angles 0..179 use the multiplier result
  assign prod = (8+DegRecipWidth)'(degrees_i[7:0]) * (8+DegRecipWidth)'(DegRecip);
  assign quot = prod[DegShift +: CmpWidth-2];

  always_comb begin
    if (degrees_i[DegWidth-1]) begin
      compare_o = IdleCompare;
    end else if (degrees_i >= MaxDegrees) begin
      compare_o = MaxCompare;
    end else begin
      compare_o = {1'b0, quot, 1'b0} + IdleCompare;
    end
  end

endmodule

// ===== sv/fcsp_timer.sv =====
module fcsp_timer import fcsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [TopWidth-1:0] period_top_i,
  input  logic                run_enable_i,
  input  fcsp_req_t           req_i,
  output fcsp_stat_t          stat_o
);

  logic [CountWidth-1:0] count_q, count_d;
  logic [CmpWidth-1:0]   active_q  [ChannelCount];
  logic [CmpWidth-1:0]   active_d  [ChannelCount];
  logic [CmpWidth-1:0]   pending_q [ChannelCount];
  logic [CmpWidth-1:0]   pending_d [ChannelCount];
  logic                  wrap;
  logic [ChannelCount-1:0] lv;

  assign wrap = req_i.tick && run_enable_i &&
                (CntCmpWidth'(count_q) >= CntCmpWidth'(period_top_i));

  always_comb begin
    count_d = count_q;
    if (req_i.tick && run_enable_i) begin
      count_d = wrap ? '0 : count_q + CountWidth'(1);
    end
    for (int i = 0; i < ChannelCount; i++) begin
      active_d[i]  = wrap ? pending_q[i] : active_q[i];
      pending_d[i] = pending_q[i];
      if (req_i.set && (req_i.idx == ChanIdxWidth'(i))) begin
        pending_d[i] = req_i.cmp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < ChannelCount; i++) begin
        active_q[i]  <= IdleCompare;
        pending_q[i] <= IdleCompare;
      end
    end else begin
      count_q <= count_d;
      for (int i = 0; i < ChannelCount; i++) begin
        active_q[i]  <= active_d[i];
        pending_q[i] <= pending_d[i];
      end
    end
  end

  // levels after this item
  always_comb begin
    for (int i = 0; i < ChannelCount; i++) begin
      lv[i] = count_d <= CountWidth'(active_d[i]);
    end
  end

  for (genvar g = 0; g < LevelWidth; g++) begin : g_lv
    if (g < ChannelCount) begin : g_on
      assign stat_o.levels[g] = lv[g];
    end else begin : g_off
      assign stat_o.levels[g] = 1'b0;
    end
  end

  assign stat_o.wrapped = wrap;

endmodule

// ===== sv/four_channel_servo_pwm_top.sv =====
// channel  dir  tdata / payload                                   tuser
// s_axis   in   [7:0] channel, [23:8] degrees                     mode
// m_axis   out  [3:0] pulse_levels, [4] period_wrapped,           -
//               [7:5] chosen_channel, [20:8] new_compare
// cfg      in   cfg_addr_i: 0 period_top, 1 run_enable; cfg_data_i
//
// one item per cycle sustained while m_axis is ready; a request passes through the input
// register and then the result register before it shows up on m_axis.
// reset: counter 0, all compares 1000, period_top 39999, timer stopped.
// a stall on m_axis holds the result register and backs up into the input
// register, then into s_axis tready; cfg is always ready.
module four_channel_servo_pwm_top import fcsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,   // channel, degrees
  input  logic                    s_axis_tuser,   // mode
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [OutDataWidth-1:0] m_axis_tdata,   // levels, wrapped, channel, compare, pad
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_addr_i,
  input  logic [TopWidth-1:0]     cfg_data_i
);

  logic                    in_valid_q;
  logic                    in_mode_q;
  logic [ChanWidth-1:0]    in_chan_q;
  logic [DegWidth-1:0]     in_deg_q;
  logic                    out_valid_q;
  logic [OutDataWidth-1:0] out_data_q, out_data_d;
  logic [TopWidth-1:0]     period_top_q;
  logic                    run_enable_q;
  logic                    advance;
  logic [ChanNumWidth-1:0] chan_num;
  logic [ChanIdxWidth-1:0] chan_idx;
  logic [CmpWidth-1:0]     compare;
  logic                    is_set;
  fcsp_req_t               req;
  fcsp_stat_t              stat;
  logic [ChosenWidth-1:0]  chosen;
  logic [CmpWidth-1:0]     cmp_out;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_top_q <= PeriodTopReset;
      run_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == CfgPeriodTop) begin
        period_top_q <= cfg_data_i;
      end
      if (cfg_addr_i == CfgRunEnable) begin
        run_enable_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q <= s_axis_tuser;
      in_chan_q <= s_axis_tdata[ChanWidth-1:0];
      in_deg_q  <= s_axis_tdata[ChanWidth +: DegWidth];
    end
  end

  fcsp_servo_map u_map (
    .channel_i  (in_chan_q),
    .degrees_i  (in_deg_q),
    .chan_num_o (chan_num),
    .chan_idx_o (chan_idx),
    .compare_o  (compare)
  );

  assign is_set = in_mode_q == ModeSet;

  always_comb begin
    req.tick = advance && (in_mode_q == ModeTick);
    req.set  = advance && is_set;
    req.idx  = chan_idx;
    req.cmp  = compare;
  end

  fcsp_timer u_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .period_top_i (period_top_q),
    .run_enable_i (run_enable_q),
    .req_i        (req),
    .stat_o       (stat)
  );

  assign chosen  = is_set ? ChosenWidth'(chan_num) : ChosenWidth'(1);
  assign cmp_out = is_set ? compare : IdleCompare;

  assign out_data_d = OutDataWidth'({cmp_out, chosen, stat.wrapped, stat.levels});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a wrap only comes from a tick, which reports the idle fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[4] |-> out_data_q[7:5] == 3'd1 && out_data_q[20:8] == IdleCompare)
    else $error("wrap reported on a set result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q[20:8] >= IdleCompare && out_data_q[20:8] <= MaxCompare)
    else $error("compare out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_deg_q) && $stable(in_chan_q))
    else $error("held request lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !run_enable_q |=> !out_data_q[4])
    else $error("wrap while stopped");

endmodule

// ===== dv/tb_four_channel_servo_pwm_top.sv =====
module tb_four_channel_servo_pwm_top import fcsp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PulseMinUs    = 500;
  localparam int PulseMaxUs    = 2500;
  localparam int PhaseCount    = 6;
  localparam int DirectedCount = 22;
  localparam int StoppedRows   = 10;  // rows run with the reset settings, timer stopped
  localparam int MaxPrinted    = 30;

  typedef struct packed {
    logic [LevelWidth-1:0]  levels;
    logic                   wrapped;
    logic [ChosenWidth-1:0] chan;
    logic [CmpWidth-1:0]    cmp;
  } servo_result_t;

  typedef struct {
    logic          mode;
    int            ch;
    int            deg;
    bit            typed;
    servo_result_t res;
  } servo_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    s_axis_tuser = ModeTick;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b1;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic                    cfg_addr_i = CfgPeriodTop;
  logic [TopWidth-1:0]     cfg_data_i = '0;

  four_channel_servo_pwm_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // servo model state
  logic [CountWidth-1:0] model_count;
  logic [CmpWidth-1:0]   model_active  [ChannelCount];
  logic [CmpWidth-1:0]   model_pending [ChannelCount];
  logic [TopWidth-1:0]   model_top;
  logic                  model_run;

  servo_result_t awaited_results[$];
  int            error_count    = 0;
  int            requests_sent  = 0;
  int            set_requests   = 0;
  int            results_seen   = 0;
  int            wraps_seen     = 0;
  int            burst_left     = 0;

  // top 65535 is only written, never reached; 1030 lands below the running count
  int unsigned phase_top      [PhaseCount] = '{1, 7, 65535, 1030, 500, 39999};
  bit          phase_run      [PhaseCount] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
  int          phase_len      [PhaseCount] = '{120, 100, 1080, 120, 80, 50};
  int          phase_tick_pct [PhaseCount] = '{60, 70, 97, 85, 70, 80};

  servo_row_t directed_rows [DirectedCount] = '{
    '{ModeTick,    0,      0, 1'b1, '{4'hF, 1'b0, 3'd1, IdleCompare}},
    '{ModeSet,     1,      0, 1'b1, '{4'hF, 1'b0, 3'd1, IdleCompare}},
    '{ModeSet,  -128, -32768, 1'b1, '{4'hF, 1'b0, 3'd1, IdleCompare}},
    '{ModeSet,   127,  32767, 1'b1, '{4'hF, 1'b0, 3'd4, MaxCompare}},
    '{ModeSet,     0,    180, 1'b1, '{4'hF, 1'b0, 3'd1, MaxCompare}},
    '{ModeSet,     4,    179, 1'b0, '0},
    '{ModeSet,     2,     90, 1'b0, '0},
    '{ModeSet,     3,      1, 1'b0, '0},
    '{ModeSet,     5,     -1, 1'b1, '{4'hF, 1'b0, 3'd4, IdleCompare}},
    '{ModeTick,    0,      0, 1'b1, '{4'hF, 1'b0, 3'd1, IdleCompare}},
    // timer running with a short period from here on
    '{ModeTick,    0,      0, 1'b0, '0},
    '{ModeTick,    0,      0, 1'b0, '0},
    '{ModeTick,    0,      0, 1'b0, '0},
    '{ModeSet,     2,    181, 1'b0, '0},
    '{ModeTick,   -1,     -1, 1'b0, '0},
    '{ModeTick,    0,      0, 1'b0, '0},
    '{ModeTick,    0,      0, 1'b0, '0},
    '{ModeSet,     3,   -100, 1'b0, '0},
    '{ModeSet,    -1,  32767, 1'b0, '0},
    '{ModeTick,    0,      0, 1'b0, '0},
    '{ModeTick,    0,      0, 1'b0, '0},
    '{ModeTick,    0,      0, 1'b0, '0}
  };

  task automatic reset_servo_model();
    model_count = '0;
    model_top   = PeriodTopReset;
    model_run   = 1'b0;
    for (int i = 0; i < ChannelCount; i++) begin
      model_active[i]  = IdleCompare;
      model_pending[i] = IdleCompare;
    end
  endtask

  task automatic advance_servo_model(input logic mode,
                                     input logic signed [ChanWidth-1:0] ch,
                                     input logic signed [DegWidth-1:0] deg,
                                     output servo_result_t r);
    int chan_num;
    int dval;
    int width_us;
    r.wrapped = 1'b0;
    r.chan    = ChosenWidth'(1);
    r.cmp     = IdleCompare;
    if (mode == ModeTick) begin
      if (model_run) begin
        if (model_count >= model_top) begin
          model_count  = '0;
          r.wrapped    = 1'b1;
          model_active = model_pending;
        end else begin
          model_count = model_count + 1'b1;
        end
      end
    end else begin
      chan_num = ch;
      if (chan_num < 1) chan_num = 1;
      if (chan_num > ChannelCount) chan_num = ChannelCount;
      dval = deg;
      if (dval < 0) begin
        width_us = PulseMinUs;
      end else begin
        width_us = dval * 100 / 9 + PulseMinUs;
        if (width_us > PulseMaxUs) width_us = PulseMaxUs;
      end
      model_pending[chan_num-1] = CmpWidth'(width_us * 2);
      r.chan = ChosenWidth'(chan_num);
      r.cmp  = CmpWidth'(width_us * 2);
    end
    for (int i = 0; i < LevelWidth; i++) begin
      r.levels[i] = (i < ChannelCount) && (model_count <= model_active[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (error_count < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %0d, awaited %0d", $realtime, what, got_v, want_v);
    end
    error_count++;
  endtask

  // both registers in one back-to-back burst, valid stays high between them
  task automatic write_timer_config(input logic [TopWidth-1:0] top, input logic run);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= CfgPeriodTop;
    cfg_data_i  <= top;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_top = top;
    cfg_addr_i <= CfgRunEnable;
    cfg_data_i <= TopWidth'(run);
    do @(posedge clk_i); while (!cfg_ready_o);
    model_run = run;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic put_request(input logic mode,
                             input logic [ChanWidth-1:0] ch,
                             input logic [DegWidth-1:0] deg,
                             input bit typed,
                             input servo_result_t typed_res);
    servo_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {deg, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_servo_model(mode, ch, deg, predicted);
    awaited_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
    if (mode == ModeSet) set_requests++;
    // bursts of random length, long unbroken ones now and then
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 11);
    end
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_request(input int tick_pct,
                              output logic mode,
                              output logic [ChanWidth-1:0] ch,
                              output logic [DegWidth-1:0] deg);
    mode = ($urandom_range(0, 99) < tick_pct) ? ModeTick : ModeSet;
    ch = ($urandom_range(0, 9) < 7) ? ChanWidth'($urandom_range(1, ChannelCount))
                                    : ChanWidth'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: deg = DegWidth'($urandom_range(0, 6));  // compares just above 1000
      4:          deg = DegWidth'($urandom_range(170, 190));
      5, 6:       deg = DegWidth'($urandom_range(0, 65535));
      7:          deg = DegWidth'(-int'($urandom_range(1, 20)));
      default:    deg = DegWidth'($urandom_range(0, 180));
    endcase
  endtask

  // receiver stall pattern, switches to a random style each time its run counter runs out
  int unsigned stall_style = 0;
  int unsigned stall_left  = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
      default: m_axis_tready <= stall_left[3];
    endcase
  end

  always @(posedge clk_i) begin : check_results
    servo_result_t got;
    servo_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.levels  = m_axis_tdata[3:0];
      got.wrapped = m_axis_tdata[4];
      got.chan    = m_axis_tdata[7:5];
      got.cmp     = m_axis_tdata[20:8];
      results_seen++;
      if (got.wrapped) wraps_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("unrequested result, new_compare", got.cmp, 0);
      end else begin
        want = awaited_results.pop_front();
        if (got.levels !== want.levels)
          report_mismatch("pulse_levels", got.levels, want.levels);
        if (got.wrapped !== want.wrapped)
          report_mismatch("period_wrapped", got.wrapped, want.wrapped);
        if (got.chan !== want.chan)
          report_mismatch("chosen_channel", got.chan, want.chan);
        if (got.cmp !== want.cmp)
          report_mismatch("new_compare", got.cmp, want.cmp);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still awaited", awaited_results.size());
    $display("FAIL four_channel_servo_pwm_top");
    $finish;
  end

  initial begin
    logic                 mode;
    logic [ChanWidth-1:0] ch;
    logic [DegWidth-1:0]  deg;
    reset_servo_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirectedCount; r++) begin
      if (r == StoppedRows) begin
        wait_all_results();
        write_timer_config(TopWidth'(2), 1'b1);
      end
      put_request(directed_rows[r].mode, ChanWidth'(directed_rows[r].ch),
                  DegWidth'(directed_rows[r].deg), directed_rows[r].typed,
                  directed_rows[r].res);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      wait_all_results();
      write_timer_config(TopWidth'(phase_top[p]), phase_run[p]);
      for (int n = 0; n < phase_len[p]; n++) begin
        pick_request(phase_tick_pct[p], mode, ch, deg);
        put_request(mode, ch, deg, 1'b0, '0);
        if (p == 2 && n == phase_len[p] / 2) wait_all_results();
      end
    end

    wait_all_results();
    repeat (4) @(posedge clk_i);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", 0, awaited_results.size());
    $display("drove %0d requests (%0d directed, %0d set-position) over %0d timer settings",
             requests_sent, DirectedCount, set_requests, PhaseCount + 2);
    $display("checked %0d results, %0d period wraps, %0d mismatches",
             results_seen, wraps_seen, error_count);
    if (error_count == 0) begin
      $display("PASS four_channel_servo_pwm_top");
    end else begin
      $display("FAIL four_channel_servo_pwm_top");
    end
    $finish;
  end

endmodule
